FILE: rtl/core/qdec_pkg.sv
// qdec_pkg: shared types and constants for the multi-channel quadrature decoder.
// Holds the x4 transition table, field widths and register address codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qdec_pkg;

  // Field widths
  localparam int SNAP_W  = 16;  // pin snapshot width
  localparam int POS_W   = 4;   // bit position field per channel
  localparam int COUNT_W = 8;   // position counter width
  localparam int CHAN_W  = 3;   // channel select width
  localparam int REG_W   = 32;  // configuration data width
  localparam int ADDR_W  = 4;   // configuration byte address width
  localparam int ACT_W   = 4;   // active channel count register width

  // Register index codes, decoded from paddr[3:2]
  localparam logic [1:0] REG_A_POS  = 2'd0;
  localparam logic [1:0] REG_B_POS  = 2'd1;
  localparam logic [1:0] REG_ACTIVE = 2'd2;

  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic [SNAP_W-1:0]         snap_t;
  typedef logic [POS_W-1:0]          pos_t;

  // Update request from the sample stage to every channel lane
  typedef struct packed {
    logic  update;    // a sample moves through and a reference reading exists
    snap_t old_snap;  // stored reading
    snap_t new_snap;  // incoming snapshot
  } sample_upd_t;

  // x4 decode: index = {oldA, oldB, newA, newB}
  function automatic count_t step_delta(input logic [3:0] idx);
    count_t d;
    case (idx)
      4'h1, 4'h7, 4'h8, 4'hE: d = -8'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: d = 8'sd1;
      default:                d = 8'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qdec_lane.sv
// qdec_lane: one encoder channel, its position counter and x4 transition decode.
// Depends on qdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdec_lane (
  input  wire                  clk,
  input  wire                  rst,
  input  qdec_pkg::sample_upd_t upd,
  input  wire                  active,
  input  qdec_pkg::pos_t       pos_a,
  input  qdec_pkg::pos_t       pos_b,
  output qdec_pkg::count_t     count
);

  logic [3:0]       idx;
  logic             moved;
  qdec_pkg::count_t count_next;

  // Transition index and change detect on this lane's phase bits
  always_comb begin
    idx   = {upd.old_snap[pos_a], upd.old_snap[pos_b],
             upd.new_snap[pos_a], upd.new_snap[pos_b]};
    moved = (idx[3] != idx[1]) || (idx[2] != idx[0]);
    count_next = count + qdec_pkg::step_delta(idx);
  end

  // Wrapping counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (upd.update && active && moved) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/multi_channel_quadrature_decoder_core.sv
// multi_channel_quadrature_decoder_core: top level of the x4 quadrature decoder.
// Depends on qdec_pkg and qdec_lane.
//
//   channel  | direction | tdata / tuser contents
//   s_axis   | in        | tdata: pins[15:0], channel[18:16]; tuser: mode
//   m_axis   | out       | tdata: count_value[7:0]; tuser: channel_present
//   apb      | config    | 0x0 a_bit_positions, 0x4 b_bit_positions, 0x8 active_channels
//
// An item is held in the input register, then decoded and either updates the counters
// (sample) or loads the result register (read); one item per cycle sustained while no read
// waits. A read waits in the input register only while the result register is full and not
// taken. Reset is synchronous and clears counters, the reference reading flag, registers and
// valid flags; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_quadrature_decoder_core #(
  parameter int CHANNELS = 8
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // input stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [23:0]                         s_axis_tdata,  // pins[15:0], channel[18:16]
  input  wire                                 s_axis_tuser,  // mode
  // result stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output qdec_pkg::count_t                    m_axis_tdata,  // count_value[7:0]
  output logic                                m_axis_tuser,  // channel_present
  // configuration
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [qdec_pkg::ADDR_W-1:0]         paddr,
  input  wire  [qdec_pkg::REG_W-1:0]          pwdata,
  output logic [qdec_pkg::REG_W-1:0]          prdata,
  output logic                                pready
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [qdec_pkg::REG_W-1:0] a_pos_reg;
  logic [qdec_pkg::REG_W-1:0] b_pos_reg;
  logic [qdec_pkg::ACT_W-1:0] active_reg;
  logic                       cfg_wr;

  // Input register
  logic                        in_valid;
  logic                        in_mode;
  qdec_pkg::snap_t             in_pins;
  logic [qdec_pkg::CHAN_W-1:0] in_chan;

  // State
  qdec_pkg::snap_t       last_snapshot;
  logic                  have_snapshot;
  qdec_pkg::count_t      counts [CHANNELS];
  qdec_pkg::sample_upd_t upd;

  logic [qdec_pkg::ACT_W-1:0] eff_n;
  logic                       in_advance;
  logic                       sample_fire;
  logic                       read_fire;
  logic                       chan_ok;

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_pos_reg  <= '0;
      b_pos_reg  <= '0;
      active_reg <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        qdec_pkg::REG_A_POS:  a_pos_reg  <= pwdata;
        qdec_pkg::REG_B_POS:  b_pos_reg  <= pwdata;
        qdec_pkg::REG_ACTIVE: active_reg <= pwdata[qdec_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      qdec_pkg::REG_A_POS:  prdata = a_pos_reg;
      qdec_pkg::REG_B_POS:  prdata = b_pos_reg;
      qdec_pkg::REG_ACTIVE: prdata = {{(qdec_pkg::REG_W-qdec_pkg::ACT_W){1'b0}}, active_reg};
      default:              prdata = '0;
    endcase
  end

  // Effective channel count, clamped to the number of lanes
  always_comb begin
    if (active_reg > qdec_pkg::ACT_W'(CHANNELS)) begin
      eff_n = qdec_pkg::ACT_W'(CHANNELS);
    end else begin
      eff_n = active_reg;
    end
  end

  // Flow control: samples always drain, reads need room in the result register
  assign in_advance    = in_valid && (!in_mode || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_advance;
  assign sample_fire   = in_advance && !in_mode;
  assign read_fire     = in_advance && in_mode;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode <= s_axis_tuser;
      in_pins <= s_axis_tdata[15:0];
      in_chan <= s_axis_tdata[18:16];
    end
  end

  // Reference reading
  always_ff @(posedge clk) begin
    if (rst) begin
      have_snapshot <= 1'b0;
      last_snapshot <= '0;
    end else if (sample_fire) begin
      have_snapshot <= 1'b1;
      last_snapshot <= in_pins;
    end
  end

  // Channel lanes
  assign upd.update   = sample_fire && have_snapshot;
  assign upd.old_snap = last_snapshot;
  assign upd.new_snap = in_pins;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    qdec_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .upd    (upd),
      .active (qdec_pkg::ACT_W'(c) < eff_n),
      .pos_a  (a_pos_reg[c*qdec_pkg::POS_W +: qdec_pkg::POS_W]),
      .pos_b  (b_pos_reg[c*qdec_pkg::POS_W +: qdec_pkg::POS_W]),
      .count  (counts[c])
    );
  end

  // Result register
  assign chan_ok = {1'b0, in_chan} < eff_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (read_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      m_axis_tuser <= chan_ok;
      m_axis_tdata <= chan_ok ? counts[in_chan[IDX_W-1:0]] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: bench/multi_channel_quadrature_decoder_core_tb.sv
// Testbench for multi_channel_quadrature_decoder_core: streams pin snapshots and counter
// reads, tracks the expected channel counters and checks every returned read.
// Depends on qdec_pkg and the decoder RTL.
`timescale 1ns / 1ps

module multi_channel_quadrature_decoder_core_tb;

  localparam int NUM_CHAN    = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 8;

  // Tracks counters and reference reading; holds the reads still owed by the block
  class qdec_count_tracker;
    typedef struct packed {
      qdec_pkg::count_t value;
      logic             present;
    } read_t;

    logic [31:0]      a_pos;
    logic [31:0]      b_pos;
    logic [3:0]       active;
    qdec_pkg::snap_t  ref_snap;
    bit               have_ref;
    qdec_pkg::count_t counts[NUM_CHAN];
    read_t            reads_due[$];
    int               mismatches;

    function new();
      a_pos = '0;
      b_pos = '0;
      active = '0;
      ref_snap = '0;
      have_ref = 1'b0;
      foreach (counts[c]) counts[c] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        qdec_pkg::REG_A_POS:  a_pos = val;
        qdec_pkg::REG_B_POS:  b_pos = val;
        qdec_pkg::REG_ACTIVE: active = val[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned live_channels();
      return (active > NUM_CHAN) ? NUM_CHAN : active;
    endfunction

    // Phase order 00 -> 10 -> 11 -> 01 mapped to 0..3; a step of one is +1, back is -1
    function qdec_pkg::count_t phase_step(logic oa, logic ob, logic na, logic nb);
      logic [1:0] g_old;
      logic [1:0] g_new;
      logic [1:0] d;
      g_old = {ob, oa ^ ob};
      g_new = {nb, na ^ nb};
      d = g_new - g_old;
      if (d == 2'd1) return 8'sd1;
      if (d == 2'd3) return -8'sd1;
      return 8'sd0;
    endfunction

    function void note_item(bit mode, qdec_pkg::snap_t pins, logic [2:0] chan);
      int unsigned n;
      qdec_pkg::snap_t prev;
      logic [3:0] pa;
      logic [3:0] pb;
      read_t r;
      n = live_channels();
      if (!mode) begin
        if (!have_ref) begin
          have_ref = 1'b1;
          ref_snap = pins;
        end else if (pins != ref_snap) begin
          prev = ref_snap;
          for (int c = 0; c < n; c++) begin
            pa = a_pos[4*c +: 4];
            pb = b_pos[4*c +: 4];
            if (prev[pa] != pins[pa] || prev[pb] != pins[pb])
              counts[c] = counts[c] + phase_step(prev[pa], prev[pb], pins[pa], pins[pb]);
          end
          ref_snap = pins;
        end
      end else begin
        r.present = (chan < n);
        r.value = r.present ? counts[chan] : 8'sd0;
        reads_due.push_back(r);
      end
    endfunction

    task report(string what, int want, int got);
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
      mismatches++;
    endtask

    task check_read(qdec_pkg::count_t got_value, logic got_present);
      read_t r;
      if (reads_due.size() == 0) begin
        report("unexpected read transfer, count", 0, got_value);
      end else begin
        r = reads_due.pop_front();
        if (got_value !== r.value) report("count_value", r.value, got_value);
        if (got_present !== r.present) report("channel_present", r.present, got_present);
      end
    endtask

    function int pending();
      return reads_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // pins[15:0], channel[18:16]
  logic        s_axis_tuser = 1'b0;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  qdec_pkg::count_t m_axis_tdata;    // count_value[7:0]
  logic        m_axis_tuser;         // channel_present
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [qdec_pkg::ADDR_W-1:0] paddr = '0;
  logic [qdec_pkg::REG_W-1:0]  pwdata = '0;
  logic [qdec_pkg::REG_W-1:0]  prdata;
  logic        pready;

  qdec_count_tracker tracker = new();

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   cycle_count = 0;
  qdec_pkg::snap_t line_pins = '0;
  bit   walk_dir[NUM_CHAN];

  multi_channel_quadrature_decoder_core #(.CHANNELS(NUM_CHAN)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each transfer, then pick tready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_read(m_axis_tdata, m_axis_tuser);
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input transfer, with a random gap in front of it
  task automatic send_item(input bit mode, input qdec_pkg::snap_t pins,
                           input logic [2:0] chan);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, chan, pins};
    s_axis_tuser <= mode;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_item(mode, pins, chan);
    if (!mode) line_pins = pins;
  endtask

  task automatic send_sample(input qdec_pkg::snap_t pins);
    send_item(1'b0, pins, 3'($urandom_range(7)));
  endtask

  task automatic send_read(input logic [2:0] chan);
    send_item(1'b1, 16'($urandom_range(16'hFFFF)), chan);
  endtask

  // Wait for all reads to return; samples may still be in flight, so pad the wait
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] act);
    wait_idle();
    cfg_write(qdec_pkg::REG_A_POS, a);
    cfg_write(qdec_pkg::REG_B_POS, b);
    cfg_write(qdec_pkg::REG_ACTIVE, act);
  endtask

  // Mostly legal quadrature steps per channel, some noise and double changes
  task automatic run_items(input int count, input int read_pct);
    qdec_pkg::snap_t w;
    logic [3:0] pa;
    logic [3:0] pb;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      w = line_pins;
      if ($urandom_range(99) < read_pct) begin
        send_read(3'($urandom_range(7)));
      end else if (roll < 8) begin
        send_sample(16'($urandom_range(16'hFFFF)));
      end else if (roll < 14) begin
        pa = tracker.a_pos[4*$urandom_range(7) +: 4];
        pb = tracker.b_pos[4*$urandom_range(7) +: 4];
        w[pa] = ~w[pa];
        w[pb] = ~w[pb];
        send_sample(w);
      end else begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          if ($urandom_range(99) < 3) walk_dir[c] = ~walk_dir[c];
          if ($urandom_range(99) < 60) begin
            pa = tracker.a_pos[4*c +: 4];
            pb = tracker.b_pos[4*c +: 4];
            // forward: flip A when phases agree, else B; backward the other way
            if ((w[pa] == w[pb]) ^ walk_dir[c]) w[pa] = ~w[pa];
            else w[pb] = ~w[pb];
          end
        end
        send_sample(w);
      end
    end
  endtask

  initial begin
    foreach (walk_dir[c]) walk_dir[c] = 1'($urandom_range(1));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: nothing active, reads before any reading, first sample only stored
    configure(32'h0, 32'h0, 32'h0);
    send_read(3'd0);
    send_read(3'd7);
    send_sample(16'h1234);
    send_sample(16'hFFFF);

    // Directed: channel c on pins 2c (A) and 2c+1 (B), all eight active
    configure(32'hECA8_6420, 32'hFDB9_7531, 32'd8);
    send_sample(16'hFFFF);   // equal to stored reading
    send_sample(16'hAAAA);   // 11 -> 01 on every channel
    send_sample(16'hAAAA);
    send_sample(16'h0000);   // 01 -> 00
    send_sample(16'h5555);   // 00 -> 10 on every channel
    send_sample(16'h0000);
    send_sample(16'h0001);   // channel 0 forward
    send_sample(16'h0000);   // and back
    for (int c = 0; c < NUM_CHAN; c++) send_read(3'(c));
    send_read(3'd0);

    // Random phases, each with its own setting and idling mix
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_items(240, 25);

    configure($urandom, $urandom, 32'd15);  // above the channel count
    send_idle_pct = 83;
    recv_stall_pct = 0;
    run_items(240, 25);

    begin
      logic [31:0] same_pos;
      same_pos = $urandom;
      configure(same_pos, same_pos, 32'd8);  // A and B on the same pin
    end
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_items(240, 25);

    configure(32'hFFFF_FFFF, 32'h0, 32'd8);  // every channel shares one pin pair
    send_idle_pct = 31;
    recv_stall_pct = 31;
    run_items(240, 25);

    configure($urandom, $urandom, 32'd3);  // upper channels frozen
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_items(240, 30);

    // Receiver holds off while reads keep coming, so the input backs up
    configure($urandom, $urandom, 32'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    run_items(230, 60);

    wait_idle();
    if (tracker.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
